/* hw/rtl/tsg_pkg.sv */
`timescale 1ns / 1ps

package tsg_pkg;

    // Default sizes
    localparam int STACK_DEPTH_DEF     = 64;
    localparam int SINE_TABLE_SIZE_DEF = 1024;

    // Field widths
    localparam int SYM_W      = 8;
    localparam int COORD_W    = 32;
    localparam int CNT_W      = 16;
    localparam int HEAD_W     = 16;
    localparam int HEAD_FRAC_W = 14;
    localparam int TRIG_W     = 16;
    localparam int SINE_MAG_W = 15;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int S_TDATA_W = SYM_W;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 4 * COORD_W + CNT_W;
    localparam int M_TUSER_W = 2;

    // Command symbols
    localparam logic [SYM_W-1:0] SYM_FORWARD = 8'h46;  // 'F'
    localparam logic [SYM_W-1:0] SYM_LEFT    = 8'h2B;  // '+'
    localparam logic [SYM_W-1:0] SYM_RIGHT   = 8'h2D;  // '-'
    localparam logic [SYM_W-1:0] SYM_PUSH    = 8'h5B;  // '['
    localparam logic [SYM_W-1:0] SYM_POP     = 8'h5D;  // ']'

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LENGTH   = 2'd0,
        CFG_TURN_AMOUNT   = 2'd1,
        CFG_SEGMENT_LIMIT = 2'd2
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] STEP_LENGTH_RESET   = 16'd256;
    localparam logic [CFG_W-1:0] TURN_AMOUNT_RESET   = 16'd4551;
    localparam logic [CFG_W-1:0] SEGMENT_LIMIT_RESET = 16'hFFFF;

    localparam logic [HEAD_W-1:0] QUARTER_TURN = 16'h4000;

    // Sine table construction constants (Q30)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // One saved turtle state
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [HEAD_W-1:0]         heading;
    } turtle_state_t;

endpackage

/* hw/rtl/turtle_segment_generator_unit.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: symbol[7:0]; s_tuser: string_start[0]
// m_       out  m_tvalid/m_tready  m_tdata: start_x, start_y, end_x, end_y,
//                                  segments_so_far; m_tuser: segment_valid,
//                                  push_overflow
// cfg_     in   cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// One item per cycle while m_ does not stall; items pass through the input and output
// registers. The rate is set by the turtle state loop: heading -> registered
// sine/cosine table read -> 16x17 multiply -> saturating add -> position register.
// Reset is synchronous on aresetn; the stack memory is not cleared, only its level.
// When m_ stalls, the input register holds one item and s_tready drops after it.
module turtle_segment_generator_unit #(
    parameter int STACK_DEPTH     = tsg_pkg::STACK_DEPTH_DEF,
    parameter int SINE_TABLE_SIZE = tsg_pkg::SINE_TABLE_SIZE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // symbol [7:0]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tsg_pkg::S_TDATA_W-1:0]  s_tdata,
    // string_start [0]
    input  logic [tsg_pkg::S_TUSER_W-1:0]  s_tuser,
    // start_x [31:0], start_y [63:32], end_x [95:64], end_y [127:96],
    // segments_so_far [143:128]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tsg_pkg::M_TDATA_W-1:0]  m_tdata,
    // segment_valid [0], push_overflow [1]
    output logic [tsg_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                           cfg_wr_en,
    input  logic [tsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsg_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int IDX_W  = $clog2(SINE_TABLE_SIZE + 1);
    localparam int PROD_W = tsg_pkg::HEAD_FRAC_W + IDX_W;
    localparam int CW     = tsg_pkg::COORD_W;
    localparam int HW     = tsg_pkg::HEAD_W;
    localparam int NW     = tsg_pkg::CNT_W;
    localparam int TW     = tsg_pkg::TRIG_W;
    localparam int MW     = tsg_pkg::SINE_MAG_W;

    // Quarter-wave sine table, built at elaboration
    typedef logic [MW-1:0] sine_rom_t [0:SINE_TABLE_SIZE];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        for (int i = 0; i <= SINE_TABLE_SIZE; i++) begin
            x  = (tsg_pkg::HALF_PI_Q30 * 64'(i)) / SINE_TABLE_SIZE;
            x2 = (x * x) >> 30;
            t  = tsg_pkg::ONE_Q30;
            t  = tsg_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
            t  = tsg_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
            t  = tsg_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
            t  = tsg_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
            t  = tsg_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
            t  = tsg_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            v  = (s * 64'd32767 + 64'd536870912) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[i] = v[MW-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Trig values for the home heading (a quarter turn): sin = table top, cos = -table[0]
    localparam logic [TW-1:0] HOME_SIN = {1'b0, SINE_ROM[SINE_TABLE_SIZE]};
    localparam logic [TW-1:0] HOME_COS = 16'd0 - {1'b0, SINE_ROM[0]};

    // Table address for a heading: quadrant bit 14 mirrors the index
    function automatic logic [IDX_W-1:0] rom_addr(input logic [HW-1:0] h);
        logic [PROD_W-1:0] scaled;
        logic [IDX_W-1:0]  idx;
        scaled = PROD_W'(h[tsg_pkg::HEAD_FRAC_W-1:0]) * PROD_W'(SINE_TABLE_SIZE);
        idx    = scaled[PROD_W-1:tsg_pkg::HEAD_FRAC_W];
        return h[tsg_pkg::HEAD_FRAC_W] ? IDX_W'(SINE_TABLE_SIZE) - idx : idx;
    endfunction

    // Move one coordinate: Q8.8 step times Q1.15 trig, round half up to Q16.16,
    // add and saturate
    function automatic logic [CW-1:0] advance(input logic [CW-1:0] p,
                                              input logic [15:0] step,
                                              input logic [TW-1:0] trig);
        logic signed [32:0] prod;
        logic signed [33:0] rnd;
        logic signed [26:0] d;
        logic signed [32:0] n;
        prod = $signed({1'b0, step}) * $signed(trig);
        rnd  = 34'(prod) + 34'sd64;
        d    = rnd[33:7];
        n    = 33'($signed(p)) + 33'(d);
        if (n[32] != n[31]) begin
            return n[32] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return n[CW-1:0];
    endfunction

    // Configuration
    logic [15:0] step_length_reg;
    logic [15:0] turn_amount_reg;
    logic [15:0] segment_limit_reg;

    // Input register
    logic                       in_vld_reg;
    logic [tsg_pkg::SYM_W-1:0]  in_sym_reg;
    logic                       in_start_reg;

    // Turtle state
    logic [CW-1:0]    pos_x_reg, pos_x_next;
    logic [CW-1:0]    pos_y_reg, pos_y_next;
    logic [HW-1:0]    heading_reg, heading_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [NW-1:0]    count_reg, count_next;

    // Stack: top entry cached, entry below it read from memory ahead of time
    tsg_pkg::turtle_state_t stack_mem [0:STACK_DEPTH-1];
    tsg_pkg::turtle_state_t top_reg, top_next;
    tsg_pkg::turtle_state_t below_reg;
    logic                   push_we;
    logic [AW-1:0]          push_addr;
    logic [AW-1:0]          below_addr;

    // Trig of the current heading, from registered table reads
    logic [MW-1:0] sin_mag_reg, cos_mag_reg;
    logic          sin_neg_reg, cos_neg_reg;
    logic [HW-1:0] head_d, cos_head_d;
    logic [LVL_W-1:0] level_d;

    // Output register
    logic                          out_vld_reg;
    logic [tsg_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [tsg_pkg::M_TUSER_W-1:0] out_user_reg, out_user_next;

    logic fire;
    logic s_accept;

    // Effective state after an optional string start
    logic [CW-1:0]    pos_x_eff, pos_y_eff;
    logic [HW-1:0]    heading_eff;
    logic [LVL_W-1:0] level_eff;
    logic [NW-1:0]    count_eff;
    logic [TW-1:0]    sin_cur, cos_cur, trig_sin, trig_cos;
    logic [CW-1:0]    new_x, new_y;
    logic             seg_valid, overflow;
    logic [CW-1:0]    sx, sy, ex, ey;

    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        sin_cur  = sin_neg_reg ? 16'd0 - {1'b0, sin_mag_reg} : {1'b0, sin_mag_reg};
        cos_cur  = cos_neg_reg ? 16'd0 - {1'b0, cos_mag_reg} : {1'b0, cos_mag_reg};

        pos_x_eff   = in_start_reg ? '0 : pos_x_reg;
        pos_y_eff   = in_start_reg ? '0 : pos_y_reg;
        heading_eff = in_start_reg ? tsg_pkg::QUARTER_TURN : heading_reg;
        level_eff   = in_start_reg ? '0 : level_reg;
        count_eff   = in_start_reg ? '0 : count_reg;
        trig_sin    = in_start_reg ? HOME_SIN : sin_cur;
        trig_cos    = in_start_reg ? HOME_COS : cos_cur;

        new_x = advance(pos_x_eff, step_length_reg, trig_cos);
        new_y = advance(pos_y_eff, step_length_reg, trig_sin);

        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        level_next   = level_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        push_we      = 1'b0;
        push_addr    = level_eff[AW-1:0];
        seg_valid    = 1'b0;
        overflow     = 1'b0;
        sx = '0;
        sy = '0;
        ex = '0;
        ey = '0;

        if (fire) begin
            pos_x_next   = pos_x_eff;
            pos_y_next   = pos_y_eff;
            heading_next = heading_eff;
            level_next   = level_eff;
            count_next   = count_eff;
            unique case (in_sym_reg)
                tsg_pkg::SYM_FORWARD: begin
                    // move always; report only while under the limit
                    if (count_eff < segment_limit_reg) begin
                        seg_valid  = 1'b1;
                        sx         = pos_x_eff;
                        sy         = pos_y_eff;
                        ex         = new_x;
                        ey         = new_y;
                        count_next = count_eff + 16'd1;
                    end
                    pos_x_next = new_x;
                    pos_y_next = new_y;
                end
                tsg_pkg::SYM_LEFT: begin
                    heading_next = heading_eff + turn_amount_reg;
                end
                tsg_pkg::SYM_RIGHT: begin
                    heading_next = heading_eff - turn_amount_reg;
                end
                tsg_pkg::SYM_PUSH: begin
                    if (level_eff != LVL_W'(STACK_DEPTH)) begin
                        push_we    = 1'b1;
                        top_next   = '{x: pos_x_eff, y: pos_y_eff, heading: heading_eff};
                        level_next = level_eff + LVL_W'(1);
                    end else begin
                        overflow = 1'b1;
                    end
                end
                tsg_pkg::SYM_POP: begin
                    // an empty stack ignores the pop
                    if (level_eff != '0) begin
                        pos_x_next   = top_reg.x;
                        pos_y_next   = top_reg.y;
                        heading_next = top_reg.heading;
                        level_next   = level_eff - LVL_W'(1);
                        top_next     = below_reg;
                    end
                end
                default: ;
            endcase
        end

        // values the state registers take at this edge, reset included
        head_d     = aresetn ? heading_next : tsg_pkg::QUARTER_TURN;
        cos_head_d = head_d + tsg_pkg::QUARTER_TURN;
        level_d    = aresetn ? level_next : '0;
        below_addr = AW'(level_d - LVL_W'(2));

        out_data_next = {count_next, ey, ex, sy, sx};
        out_user_next = {overflow, seg_valid};
    end

    // Table reads are registered from the heading register's next value, so they match it
    always_ff @(posedge aclk) begin
        sin_mag_reg <= SINE_ROM[rom_addr(head_d)];
        cos_mag_reg <= SINE_ROM[rom_addr(cos_head_d)];
        sin_neg_reg <= head_d[HW-1];
        cos_neg_reg <= cos_head_d[HW-1];
    end

    // Stack memory: write on push, keep the entry below the top read out
    always_ff @(posedge aclk) begin
        if (push_we) begin
            stack_mem[push_addr] <= top_next;
        end
        below_reg <= stack_mem[below_addr];
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (s_accept) begin
            in_sym_reg   <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
        if (fire) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= tsg_pkg::QUARTER_TURN;
            level_reg   <= '0;
            count_reg   <= '0;
        end else begin
            // hold the input item until it moves to the output register
            if (s_accept) begin
                in_vld_reg <= 1'b1;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end
            if (fire) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
            level_reg   <= level_next;
            count_reg   <= count_next;
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_length_reg   <= tsg_pkg::STEP_LENGTH_RESET;
            turn_amount_reg   <= tsg_pkg::TURN_AMOUNT_RESET;
            segment_limit_reg <= tsg_pkg::SEGMENT_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tsg_pkg::CFG_STEP_LENGTH:   step_length_reg   <= cfg_wdata;
                tsg_pkg::CFG_TURN_AMOUNT:   turn_amount_reg   <= cfg_wdata;
                tsg_pkg::CFG_SEGMENT_LIMIT: segment_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

/* hw/rtl/tsg_checker.sv */
`timescale 1ns / 1ps

module tsg_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tsg_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [tsg_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int SEG_W = 4 * tsg_pkg::COORD_W;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // No segment means zero coordinates
    a_zero_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[SEG_W-1:0] == '0)
        else $error("coordinates set without a segment");

    // A push overflow never comes with a segment
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("segment and push overflow together");

    // Nothing is offered straight after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind turtle_segment_generator_unit tsg_checker u_tsg_checker (.*);

/* dv/turtle_segment_generator_unit_test.sv */
`timescale 1ns / 1ps

module turtle_segment_generator_unit_test;

    import tsg_pkg::*;

    localparam int NEST_DEPTH = STACK_DEPTH_DEF;
    localparam int SINE_N     = SINE_TABLE_SIZE_DEF;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    // One result item as the block reports it
    typedef struct packed {
        logic               seg_valid;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic [15:0]        seg_count;
        logic               push_ovf;
    } segment_t;

    // One symbol to send; typed items carry their own expected result
    typedef struct packed {
        logic [7:0] sym;
        logic       restart;
        logic       typed;
        segment_t   want;
    } symbol_item_t;

    // Directed row: symbol repeated reps times, result typed in where obvious
    typedef struct packed {
        logic [7:0]  sym;
        logic        restart;
        logic [7:0]  reps;
        logic        typed;
        logic [15:0] count;
        logic        ovf;
    } step_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // symbol [7:0]
    logic [S_TUSER_W-1:0]  s_tuser = '0;   // string_start [0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // start_x, start_y, end_x, end_y, segments_so_far (lowest bit up)
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;         // segment_valid [0], push_overflow [1]
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    turtle_segment_generator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Turtle copy kept alongside the block
    logic [15:0]        step_len  = STEP_LENGTH_RESET;
    logic [15:0]        turn_amt  = TURN_AMOUNT_RESET;
    logic [15:0]        seg_limit = SEGMENT_LIMIT_RESET;
    logic signed [31:0] walk_x = '0;
    logic signed [31:0] walk_y = '0;
    logic [15:0]        walk_heading = QUARTER_TURN;
    int                 nest_level = 0;
    logic signed [31:0] nest_x [NEST_DEPTH];
    logic signed [31:0] nest_y [NEST_DEPTH];
    logic [15:0]        nest_heading [NEST_DEPTH];
    logic [15:0]        drawn_count = '0;
    int                 sine_lut [0:SINE_N];

    symbol_item_t stim_q[$];
    segment_t     seg_q[$];
    int           mismatches = 0;

    // Quarter-wave sine in Q1.15: fixed Q30 series, truncating steps, round half up
    initial begin
        longint unsigned divs [6];
        longint unsigned x, x2, t, s, v;
        divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        for (int i = 0; i <= SINE_N; i++) begin
            x  = (HALF_PI_Q30 * longint'(i)) / longint'(SINE_N);
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (int k = 0; k < 6; k++) begin
                t = ONE_Q30 - ((x2 * t) >> 30) / divs[k];
            end
            s = (x * t) >> 30;
            v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767) v = 64'd32767;
            sine_lut[i] = int'(v);
        end
    end

    function automatic int sine_of(logic [15:0] h);
        int idx;
        int v;
        idx = (int'(h[13:0]) * SINE_N) >> 14;
        if (idx > SINE_N) idx = SINE_N;
        v = h[14] ? sine_lut[SINE_N - idx] : sine_lut[idx];
        return h[15] ? -v : v;
    endfunction

    // Move one coordinate: Q9.23 product rounded to Q16.16, then saturate
    function automatic logic signed [31:0] advance(logic signed [31:0] p, int trig);
        longint d;
        longint n;
        d = (longint'(step_len) * longint'(trig) + 64) >>> 7;
        n = longint'(p) + d;
        if (n > COORD_MAX) n = COORD_MAX;
        if (n < COORD_MIN) n = COORD_MIN;
        return n[31:0];
    endfunction

    function automatic void go_home();
        walk_x       = '0;
        walk_y       = '0;
        walk_heading = QUARTER_TURN;
        nest_level   = 0;
        drawn_count  = '0;
    endfunction

    // Advance the turtle copy by one symbol and return the result it causes
    function automatic segment_t predict_segment(symbol_item_t it);
        segment_t r;
        logic signed [31:0] nx, ny;
        r = '0;
        if (it.restart) go_home();
        case (it.sym)
            SYM_FORWARD: begin
                nx = advance(walk_x, sine_of(walk_heading + QUARTER_TURN));
                ny = advance(walk_y, sine_of(walk_heading));
                // past the limit the turtle still moves, it just draws nothing
                if (drawn_count < seg_limit) begin
                    r.seg_valid = 1'b1;
                    r.start_x   = walk_x;
                    r.start_y   = walk_y;
                    r.end_x     = nx;
                    r.end_y     = ny;
                    drawn_count = drawn_count + 16'd1;
                end
                walk_x = nx;
                walk_y = ny;
            end
            SYM_LEFT:  walk_heading = walk_heading + turn_amt;
            SYM_RIGHT: walk_heading = walk_heading - turn_amt;
            SYM_PUSH: begin
                if (nest_level < NEST_DEPTH) begin
                    nest_x[nest_level]       = walk_x;
                    nest_y[nest_level]       = walk_y;
                    nest_heading[nest_level] = walk_heading;
                    nest_level++;
                end else begin
                    r.push_ovf = 1'b1;
                end
            end
            SYM_POP: begin
                if (nest_level > 0) begin
                    nest_level--;
                    walk_x       = nest_x[nest_level];
                    walk_y       = nest_y[nest_level];
                    walk_heading = nest_heading[nest_level];
                end
            end
            default: ;
        endcase
        r.seg_count = drawn_count;
        return r;
    endfunction

    function automatic void note_error(string msg);
        if (mismatches < 10) $display("%0t ERROR %s", $time, msg);
        mismatches++;
    endfunction

    // Result side: check each accepted item, stall on a pattern of its own
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    always @(posedge aclk) begin
        segment_t got, want;
        logic     ready_next;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.start_x   = m_tdata[31:0];
            got.start_y   = m_tdata[63:32];
            got.end_x     = m_tdata[95:64];
            got.end_y     = m_tdata[127:96];
            got.seg_count = m_tdata[143:128];
            got.seg_valid = m_tuser[0];
            got.push_ovf  = m_tuser[1];
            if (seg_q.size() == 0) begin
                note_error("result item with nothing expected");
            end else begin
                want = seg_q.pop_front();
                if (got !== want) begin
                    note_error($sformatf({"want v=%0b s=(%0d,%0d) e=(%0d,%0d) n=%0d ovf=%0b",
                        " got v=%0b s=(%0d,%0d) e=(%0d,%0d) n=%0d ovf=%0b"},
                        want.seg_valid, want.start_x, want.start_y, want.end_x,
                        want.end_y, want.seg_count, want.push_ovf,
                        got.seg_valid, got.start_x, got.start_y, got.end_x,
                        got.end_y, got.seg_count, got.push_ovf));
                end
            end
        end
        // switch between always ready, random stalls and a sparse fixed beat
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(32, 200);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            0:       ready_next = 1'b1;
            1:       ready_next = ($urandom_range(0, 3) != 0);
            default: ready_next = (stall_tick % 5 == 0);
        endcase
        m_tready <= ready_next;
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_STEP_LENGTH:   step_len  = value;
            CFG_TURN_AMOUNT:   turn_amt  = value;
            CFG_SEGMENT_LIMIT: seg_limit = value;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] step, logic [15:0] turn, logic [15:0] limit);
        write_reg(CFG_STEP_LENGTH, step);
        write_reg(CFG_TURN_AMOUNT, turn);
        write_reg(CFG_SEGMENT_LIMIT, limit);
    endtask

    // Straight run: restart, turn a few times, then a long stretch of forwards
    task automatic queue_walk(logic [7:0] turn_sym, int turns, int steps);
        symbol_item_t it;
        it = '0;
        it.sym     = turn_sym;
        it.restart = 1'b1;
        stim_q.push_back(it);
        it.restart = 1'b0;
        repeat (turns - 1) stim_q.push_back(it);
        it.sym = SYM_FORWARD;
        repeat (steps) stim_q.push_back(it);
    endtask

    // Mostly well-formed strings with random content, some noise and stray pops
    task automatic queue_strings(int total, int fwd_pct);
        symbol_item_t it;
        int len, depth, pick, k;
        bit deep;
        while (total > 0) begin
            deep = ($urandom_range(0, 11) == 0);
            if (deep) len = $urandom_range(70, 120);
            else if ($urandom_range(0, 7) == 0) len = $urandom_range(60, 160);
            else len = $urandom_range(3, 40);
            depth = 0;
            for (k = 0; k < len && total > 0; k++) begin
                it = '0;
                if (k == 0) it.restart = deep || ($urandom_range(0, 15) != 0);
                else it.restart = ($urandom_range(0, 199) == 0);
                pick = $urandom_range(0, 99);
                if (deep && k < 66) begin
                    // drive the stack past full
                    it.sym = SYM_PUSH;
                end else if (pick < fwd_pct) begin
                    it.sym = SYM_FORWARD;
                end else if (pick >= 92) begin
                    it.sym = 8'($urandom_range(0, 255));
                end else begin
                    case (pick % 4)
                        0: it.sym = SYM_LEFT;
                        1: it.sym = SYM_RIGHT;
                        2: it.sym = SYM_PUSH;
                        default: begin
                            // keep a stray pop now and then, else open a branch
                            if (depth > 0 || $urandom_range(0, 3) == 0) it.sym = SYM_POP;
                            else it.sym = SYM_PUSH;
                        end
                    endcase
                end
                if (it.restart) depth = 0;
                if (it.sym == SYM_PUSH) depth++;
                if (it.sym == SYM_POP && depth > 0) depth--;
                stim_q.push_back(it);
                total--;
            end
        end
    endtask

    // Send the queued items in bursts, then let every result come home
    task automatic play_and_drain();
        symbol_item_t cur;
        segment_t want;
        int burst_left, gap_left;
        bit hold_for_drain;
        logic next_valid;
        burst_left     = $urandom_range(1, 60);
        gap_left       = 0;
        hold_for_drain = 1'b0;
        while (stim_q.size() > 0 || s_tvalid) begin
            @(posedge aclk);
            if (s_tvalid && s_tready) begin
                cur  = stim_q.pop_front();
                want = predict_segment(cur);
                if (cur.typed) want = cur.want;
                seg_q.push_back(want);
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left     = $urandom_range(1, 60);
                    gap_left       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    hold_for_drain = ($urandom_range(0, 15) == 0);
                end
            end
            // change the bus only when the current item has gone or none is offered
            if (!s_tvalid || s_tready) begin
                if (hold_for_drain && seg_q.size() == 0) hold_for_drain = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                    next_valid = 1'b0;
                end else begin
                    next_valid = !hold_for_drain && stim_q.size() > 0;
                end
                s_tvalid <= next_valid;
                if (next_valid) begin
                    s_tdata <= stim_q[0].sym;
                    s_tuser <= stim_q[0].restart;
                end
            end
        end
        while (seg_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        step_row_t rows [20];
        symbol_item_t it;
        rows = '{
            // unknown symbol straight after reset
            '{8'h00,       1'b0, 8'd1,  1'b1, 16'd0,  1'b0},
            // pop with nothing saved
            '{SYM_POP,     1'b0, 8'd1,  1'b1, 16'd0,  1'b0},
            '{8'hFF,       1'b1, 8'd1,  1'b1, 16'd0,  1'b0},
            '{SYM_FORWARD, 1'b0, 8'd1,  1'b0, 16'd0,  1'b0},
            '{SYM_LEFT,    1'b0, 8'd1,  1'b1, 16'd1,  1'b0},
            '{SYM_FORWARD, 1'b0, 8'd2,  1'b0, 16'd0,  1'b0},
            '{SYM_RIGHT,   1'b0, 8'd3,  1'b1, 16'd3,  1'b0},
            '{SYM_FORWARD, 1'b0, 8'd1,  1'b0, 16'd0,  1'b0},
            '{SYM_PUSH,    1'b0, 8'd1,  1'b1, 16'd4,  1'b0},
            '{SYM_FORWARD, 1'b0, 8'd4,  1'b0, 16'd0,  1'b0},
            '{SYM_POP,     1'b0, 8'd1,  1'b1, 16'd8,  1'b0},
            '{SYM_FORWARD, 1'b0, 8'd1,  1'b0, 16'd0,  1'b0},
            // fill the stack to the brim, then one push too many
            '{SYM_PUSH,    1'b0, 8'd64, 1'b1, 16'd9,  1'b0},
            '{SYM_PUSH,    1'b0, 8'd1,  1'b1, 16'd9,  1'b1},
            '{SYM_FORWARD, 1'b0, 8'd1,  1'b0, 16'd0,  1'b0},
            '{SYM_POP,     1'b0, 8'd64, 1'b0, 16'd0,  1'b0},
            '{SYM_POP,     1'b0, 8'd1,  1'b1, 16'd10, 1'b0},
            '{SYM_LEFT,    1'b0, 8'd8,  1'b0, 16'd0,  1'b0},
            '{SYM_FORWARD, 1'b0, 8'd3,  1'b0, 16'd0,  1'b0},
            // string start on a forward move
            '{SYM_FORWARD, 1'b1, 8'd1,  1'b0, 16'd0,  1'b0}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed part, reset configuration
        foreach (rows[i]) begin
            it = '0;
            it.sym             = rows[i].sym;
            it.restart         = rows[i].restart;
            it.typed           = rows[i].typed;
            it.want.seg_count  = rows[i].count;
            it.want.push_ovf   = rows[i].ovf;
            repeat (rows[i].reps) stim_q.push_back(it);
        end
        play_and_drain();

        // longest step, no turning: run into the upper edge
        set_config(16'hFFFF, 16'd0, 16'hFFFF);
        queue_walk(SYM_LEFT, 1, 140);
        queue_strings(80, 85);
        play_and_drain();

        // zero step and tiny limit
        set_config(16'd0, 16'hFFFF, 16'd5);
        queue_strings(60, 50);
        play_and_drain();

        // nothing may be drawn at all
        set_config(16'h8000, 16'd16384, 16'd0);
        queue_strings(50, 60);
        play_and_drain();

        repeat (3) begin
            set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(1, 40)));
            queue_strings(80, 45);
            play_and_drain();
        end

        // longest step, quarter turns: saturate on the left, right and lower edges
        set_config(16'hFFFF, 16'd16384, 16'hFFFF);
        queue_walk(SYM_LEFT, 1, 140);
        queue_walk(SYM_RIGHT, 1, 140);
        queue_walk(SYM_LEFT, 2, 140);
        queue_strings(80, 70);
        play_and_drain();

        set_config(16'd1, 16'd1, 16'hFFFF);
        queue_strings(60, 50);
        play_and_drain();

        set_config(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)), 16'hFFFF);
        queue_strings(60, 55);
        play_and_drain();

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
